// File: rtl/core/dilf_pkg.sv
`timescale 1ns / 1ps

package dilf_pkg;

  localparam int LINE_CHARS_DEF = 32;
  localparam int ID_CHARS_DEF   = 10;

  localparam int ADDR_W = 4;

  localparam logic [7:0]  START_CHAR_RST = 8'd91;
  localparam logic [7:0]  END_CHAR_RST   = 8'd93;
  localparam logic [31:0] DEVICE_ID_RST  = 32'd0;
  localparam logic [15:0] DEAD_MS_RST    = 16'd1500;

  localparam logic [16:0] IDLE_MAX = 17'h1FFFF;

  localparam logic [7:0] CHAR_CTRL_MAX = 8'h1F;
  localparam logic [7:0] CHAR_DEL      = 8'h7F;
  localparam logic [7:0] CHAR_CR       = 8'h0D;
  localparam logic [7:0] CHAR_LF       = 8'h0A;
  localparam logic [7:0] CHAR_TAB      = 8'h09;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;
  localparam logic [7:0] CHAR_PLUS     = 8'h2B;
  localparam logic [7:0] CHAR_MINUS    = 8'h2D;
  localparam logic [7:0] CHAR_ZERO     = 8'h30;
  localparam logic [7:0] CHAR_NINE     = 8'h39;
  localparam logic [7:0] CHAR_LC_A     = 8'h61;
  localparam logic [7:0] CHAR_LC_F     = 8'h66;
  localparam logic [7:0] CHAR_UC_A     = 8'h41;
  localparam logic [7:0] CHAR_UC_F     = 8'h46;
  localparam logic [7:0] CHAR_LC_X     = 8'h78;
  localparam logic [7:0] CASE_BIT      = 8'h20;
  localparam logic [5:0] DIGIT_NONE    = 6'd36;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_START = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    EV_CHAR  = 2'd0,
    EV_ALIVE = 2'd1,
    EV_DEAD  = 2'd2,
    EV_FAIL  = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    REG_START_CHAR = 2'd0,
    REG_END_CHAR   = 2'd1,
    REG_DEVICE_ID  = 2'd2,
    REG_DEAD_MS    = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    BASE_8,
    BASE_10,
    BASE_16
  } base_t;

  typedef enum logic [3:0] {
    ST_ENDED,
    ST_SEEK,
    ST_ID,
    ST_LINE,
    ST_FAULT,
    ST_PWS,
    ST_PSIGN,
    ST_PZERO,
    ST_PX,
    ST_PHEX,
    ST_PDIG,
    ST_PCMP,
    ST_FETCH,
    ST_PUT
  } state_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic [7:0] data_byte;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic   sess_clear;
    logic   idle_inc;
    logic   idle_clr;
    logic   id_clear;
    logic   id_wr;
    logic   line_clear;
    logic   line_wr;
    logic   alive_set;
    logic   parse_init;
    logic   p_inc;
    logic   neg_load;
    logic   base_load;
    base_t  base_val;
    logic   acc_step;
    logic   rd_clear;
    logic   rd_inc;
    logic   out_load;
    event_t out_ev;
    logic   out_char;
    logic   out_last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic timeout;
    logic alive;
    logic id_full;
    logic id_empty;
    logic line_full;
    logic line_empty;
    logic rx_start;
    logic rx_end;
    logic rx_print;
    logic rx_term;
    logic p_lt_n;
    logic c_space;
    logic c_sign;
    logic c_zero;
    logic c_x;
    logic c_hex;
    logic c_digit_ok;
    logic id_match;
    logic rd_last;
  } stat_t;

endpackage

// File: rtl/core/dilf_ctrl.sv
`timescale 1ns / 1ps

module dilf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [1:0]       opcode,
  input  dilf_pkg::stat_t  stat,
  output logic             in_ready,
  output dilf_pkg::cmd_t   cmd
);

  dilf_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dilf_pkg::ST_ENDED;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      dilf_pkg::ST_ENDED, dilf_pkg::ST_SEEK, dilf_pkg::ST_ID,
      dilf_pkg::ST_LINE, dilf_pkg::ST_FAULT: begin
        in_ready = stat.out_free;
        if (in_valid && stat.out_free) begin
          if (opcode == dilf_pkg::OP_START) begin
            cmd.sess_clear = 1'b1;
            state_next     = dilf_pkg::ST_SEEK;
          end else if (state != dilf_pkg::ST_ENDED && opcode == dilf_pkg::OP_TICK) begin
            cmd.idle_inc = 1'b1;
            if (stat.timeout) begin
              cmd.out_load = 1'b1;
              cmd.out_ev   = stat.alive ? dilf_pkg::EV_DEAD : dilf_pkg::EV_FAIL;
              cmd.out_last = 1'b1;
              state_next   = dilf_pkg::ST_ENDED;
            end
          end else if (state != dilf_pkg::ST_ENDED && opcode == dilf_pkg::OP_BYTE) begin
            cmd.idle_clr = 1'b1;
            unique case (state)
              dilf_pkg::ST_FAULT: begin
                cmd.out_load = 1'b1;
                cmd.out_ev   = stat.alive ? dilf_pkg::EV_DEAD : dilf_pkg::EV_FAIL;
                cmd.out_last = 1'b1;
                state_next   = dilf_pkg::ST_ENDED;
              end
              dilf_pkg::ST_SEEK: begin
                if (stat.rx_start) begin
                  cmd.id_clear = 1'b1;
                  state_next   = dilf_pkg::ST_ID;
                end
              end
              dilf_pkg::ST_ID: begin
                if (stat.id_full) begin
                  state_next = dilf_pkg::ST_FAULT;
                end else if (stat.rx_end) begin
                  if (!stat.id_empty) begin
                    cmd.parse_init = 1'b1;
                    state_next     = dilf_pkg::ST_PWS;
                  end else begin
                    state_next = dilf_pkg::ST_SEEK;
                  end
                end else begin
                  cmd.id_wr = 1'b1;
                end
              end
              dilf_pkg::ST_LINE: begin
                if (stat.rx_print) begin
                  cmd.line_wr = !stat.line_full;
                end else if (stat.rx_term) begin
                  if (!stat.alive) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_ev    = dilf_pkg::EV_ALIVE;
                    cmd.out_last  = stat.line_empty;
                    cmd.alive_set = 1'b1;
                  end
                  if (stat.line_empty) begin
                    state_next = dilf_pkg::ST_SEEK;
                  end else begin
                    cmd.rd_clear = 1'b1;
                    state_next   = dilf_pkg::ST_FETCH;
                  end
                end
              end
              default: begin
                state_next = dilf_pkg::ST_ENDED;
              end
            endcase
          end
        end
      end
      dilf_pkg::ST_PWS: begin
        if (stat.p_lt_n && stat.c_space) begin
          cmd.p_inc = 1'b1;
        end else begin
          state_next = dilf_pkg::ST_PSIGN;
        end
      end
      dilf_pkg::ST_PSIGN: begin
        if (stat.p_lt_n && stat.c_sign) begin
          cmd.neg_load = 1'b1;
          cmd.p_inc    = 1'b1;
        end
        state_next = dilf_pkg::ST_PZERO;
      end
      dilf_pkg::ST_PZERO: begin
        if (stat.p_lt_n && stat.c_zero) begin
          cmd.base_load = 1'b1;
          cmd.base_val  = dilf_pkg::BASE_8;
          cmd.p_inc     = 1'b1;
          state_next    = dilf_pkg::ST_PX;
        end else begin
          state_next = dilf_pkg::ST_PDIG;
        end
      end
      dilf_pkg::ST_PX: begin
        if (stat.p_lt_n && stat.c_x) begin
          cmd.p_inc  = 1'b1;
          state_next = dilf_pkg::ST_PHEX;
        end else begin
          state_next = dilf_pkg::ST_PDIG;
        end
      end
      dilf_pkg::ST_PHEX: begin
        if (stat.p_lt_n && stat.c_hex) begin
          cmd.base_load = 1'b1;
          cmd.base_val  = dilf_pkg::BASE_16;
          state_next    = dilf_pkg::ST_PDIG;
        end else begin
          state_next = dilf_pkg::ST_PCMP;
        end
      end
      dilf_pkg::ST_PDIG: begin
        if (stat.p_lt_n && stat.c_digit_ok) begin
          cmd.acc_step = 1'b1;
          cmd.p_inc    = 1'b1;
        end else begin
          state_next = dilf_pkg::ST_PCMP;
        end
      end
      dilf_pkg::ST_PCMP: begin
        if (stat.id_match) begin
          cmd.line_clear = 1'b1;
          state_next     = dilf_pkg::ST_LINE;
        end else begin
          state_next = dilf_pkg::ST_FAULT;
        end
      end
      dilf_pkg::ST_FETCH: begin
        state_next = dilf_pkg::ST_PUT;
      end
      dilf_pkg::ST_PUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_ev   = dilf_pkg::EV_CHAR;
          cmd.out_char = 1'b1;
          cmd.out_last = stat.rd_last;
          cmd.rd_inc   = 1'b1;
          state_next   = stat.rd_last ? dilf_pkg::ST_SEEK : dilf_pkg::ST_FETCH;
        end
      end
      default: begin
        state_next = dilf_pkg::ST_ENDED;
      end
    endcase
  end

endmodule

// File: rtl/core/dilf_dp.sv
`timescale 1ns / 1ps

module dilf_dp #(
  parameter int LINE_CHARS = dilf_pkg::LINE_CHARS_DEF,
  parameter int ID_CHARS   = dilf_pkg::ID_CHARS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  dilf_pkg::cmd_t      cmd,
  input  logic [7:0]          rx_byte,
  input  logic [7:0]          start_char,
  input  logic [7:0]          end_char,
  input  logic signed [31:0]  device_id,
  input  logic [15:0]         dead_after_ms,
  input  logic                out_ready,
  output dilf_pkg::stat_t     stat,
  output logic                out_valid,
  output dilf_pkg::out_word_t out_data
);

  localparam int IW  = $clog2(ID_CHARS);
  localparam int ICW = $clog2(ID_CHARS + 1);
  localparam int LW  = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;
  localparam int LCW = $clog2(LINE_CHARS + 1);

  function automatic logic [5:0] digit_value(input logic [7:0] ch);
    logic [5:0] v;
    if (ch >= dilf_pkg::CHAR_ZERO && ch <= dilf_pkg::CHAR_NINE) begin
      v = 6'(ch - dilf_pkg::CHAR_ZERO);
    end else if (ch >= dilf_pkg::CHAR_LC_A && ch <= dilf_pkg::CHAR_LC_F) begin
      v = 6'(ch - dilf_pkg::CHAR_LC_A) + 6'd10;
    end else if (ch >= dilf_pkg::CHAR_UC_A && ch <= dilf_pkg::CHAR_UC_F) begin
      v = 6'(ch - dilf_pkg::CHAR_UC_A) + 6'd10;
    end else begin
      v = dilf_pkg::DIGIT_NONE;
    end
    return v;
  endfunction

  logic [7:0]       id_mem [ID_CHARS];
  logic [ICW-1:0]   id_count;
  logic [ICW-1:0]   p;
  logic [ICW-1:0]   p_next;
  logic [7:0]       line_mem [LINE_CHARS];
  logic [7:0]       line_q;
  logic [LCW-1:0]   line_count;
  logic [LW-1:0]    rd;
  logic             alive;
  logic [16:0]      idle_ms;
  logic [16:0]      idle_sat;
  logic [31:0]      acc;
  logic [31:0]      acc_mul;
  logic [31:0]      acc_next;
  logic [31:0]      acc_signed;
  logic             neg;
  dilf_pkg::base_t  base;
  logic [5:0]       base_num;
  logic [7:0]       c;
  logic [5:0]       c_val;

  assign p_next = cmd.parse_init ? '0 : (cmd.p_inc ? p + ICW'(1) : p);
  assign c_val  = digit_value(c);

  always_comb begin
    unique case (base)
      dilf_pkg::BASE_8: begin
        acc_mul  = acc << 3;
        base_num = 6'd8;
      end
      dilf_pkg::BASE_16: begin
        acc_mul  = acc << 4;
        base_num = 6'd16;
      end
      default: begin
        acc_mul  = (acc << 3) + (acc << 1);
        base_num = 6'd10;
      end
    endcase
  end

  assign acc_next   = acc_mul + {26'd0, c_val};
  assign acc_signed = neg ? (32'd0 - acc) : acc;
  assign idle_sat   = (idle_ms == dilf_pkg::IDLE_MAX) ? idle_ms : idle_ms + 17'd1;

  always_comb begin
    stat            = '0;
    stat.out_free   = !out_valid || out_ready;
    stat.timeout    = idle_sat > {1'b0, dead_after_ms};
    stat.alive      = alive;
    stat.id_full    = id_count == ICW'(ID_CHARS);
    stat.id_empty   = id_count == '0;
    stat.line_full  = line_count == LCW'(LINE_CHARS);
    stat.line_empty = line_count == '0;
    stat.rx_start   = rx_byte == start_char;
    stat.rx_end     = rx_byte == end_char;
    stat.rx_print   = rx_byte > dilf_pkg::CHAR_CTRL_MAX && rx_byte < dilf_pkg::CHAR_DEL;
    stat.rx_term    = rx_byte == dilf_pkg::CHAR_CR || rx_byte == dilf_pkg::CHAR_LF;
    stat.p_lt_n     = p < id_count;
    stat.c_space    = c == dilf_pkg::CHAR_SPACE ||
                      (c >= dilf_pkg::CHAR_TAB && c <= dilf_pkg::CHAR_CR);
    stat.c_sign     = c == dilf_pkg::CHAR_PLUS || c == dilf_pkg::CHAR_MINUS;
    stat.c_zero     = c == dilf_pkg::CHAR_ZERO;
    stat.c_x        = (c | dilf_pkg::CASE_BIT) == dilf_pkg::CHAR_LC_X;
    stat.c_hex      = c_val < 6'd16;
    stat.c_digit_ok = c_val < base_num;
    stat.id_match   = acc_signed == $unsigned(device_id);
    stat.rd_last    = ({1'b0, LCW'(rd)} + {{LCW{1'b0}}, 1'b1}) == {1'b0, line_count};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      id_count   <= '0;
      line_count <= '0;
      alive      <= 1'b0;
      idle_ms    <= '0;
    end else if (cmd.sess_clear) begin
      id_count   <= '0;
      line_count <= '0;
      alive      <= 1'b0;
      idle_ms    <= '0;
    end else begin
      if (cmd.idle_inc) begin
        idle_ms <= idle_sat;
      end else if (cmd.idle_clr) begin
        idle_ms <= '0;
      end
      if (cmd.id_clear) begin
        id_count <= '0;
      end else if (cmd.id_wr) begin
        id_count <= id_count + ICW'(1);
      end
      if (cmd.line_clear) begin
        line_count <= '0;
      end else if (cmd.line_wr) begin
        line_count <= line_count + LCW'(1);
      end
      if (cmd.alive_set) begin
        alive <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p <= '0;
    end else begin
      p <= p_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.parse_init) begin
      acc  <= '0;
      neg  <= 1'b0;
      base <= dilf_pkg::BASE_10;
    end else begin
      if (cmd.acc_step) begin
        acc <= acc_next;
      end
      if (cmd.neg_load) begin
        neg <= c == dilf_pkg::CHAR_MINUS;
      end
      if (cmd.base_load) begin
        base <= cmd.base_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd <= '0;
    end else if (cmd.rd_clear) begin
      rd <= '0;
    end else if (cmd.rd_inc) begin
      rd <= rd + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.id_wr) begin
      id_mem[id_count[IW-1:0]] <= rx_byte;
    end
    c <= id_mem[p_next[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.line_wr) begin
      line_mem[line_count[LW-1:0]] <= rx_byte;
    end
    line_q <= line_mem[rd];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.event_res <= cmd.out_ev;
      out_data.data_byte <= cmd.out_char ? line_q : 8'd0;
      out_data.last      <= cmd.out_last;
    end
  end

endmodule

// File: rtl/core/device_id_line_framer.sv
`timescale 1ns / 1ps

// Frames a serial device stream into text lines after an identifier handshake.
// Input channel (in_valid/in_ready/in_data): one word per received byte,
// millisecond tick or session start. Output channel (out_valid/out_ready/
// out_data): line characters and alive/dead/fail events, last set on the
// final word caused by an input word. APB port: start_char, end_char,
// device_id, dead_after_ms at byte addresses 0, 4, 8, 12.
// A result caused directly by an input word is in the output register in the
// cycle after acceptance. Most input words leave the controller in a state
// that takes the next word. The end character of an identifier starts a parse
// that walks the stored characters with in_ready low. A line terminator emits
// the alive event if the session is not yet alive, then each stored character
// through the FETCH and PUT states (line memory has a registered read port).
// Reset: registers return to their defaults, no session is open, and input
// bytes and ticks are ignored until a session start word arrives.
// Stall: in_ready stays low while the output register holds a word that
// the receiver has not taken; line emission pauses until it is taken.
module device_id_line_framer #(
  parameter int LINE_CHARS = dilf_pkg::LINE_CHARS_DEF,
  parameter int ID_CHARS   = dilf_pkg::ID_CHARS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  dilf_pkg::in_word_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output dilf_pkg::out_word_t         out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dilf_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [7:0]         start_char;
  logic [7:0]         end_char;
  logic signed [31:0] device_id;
  logic [15:0]        dead_after_ms;
  dilf_pkg::reg_idx_t reg_idx;
  dilf_pkg::cmd_t     cmd;
  dilf_pkg::stat_t    stat;

  assign pready  = 1'b1;
  assign reg_idx = dilf_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_char    <= dilf_pkg::START_CHAR_RST;
      end_char      <= dilf_pkg::END_CHAR_RST;
      device_id     <= dilf_pkg::DEVICE_ID_RST;
      dead_after_ms <= dilf_pkg::DEAD_MS_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        dilf_pkg::REG_START_CHAR: start_char    <= pwdata[7:0];
        dilf_pkg::REG_END_CHAR:   end_char      <= pwdata[7:0];
        dilf_pkg::REG_DEVICE_ID:  device_id     <= pwdata;
        dilf_pkg::REG_DEAD_MS:    dead_after_ms <= pwdata[15:0];
        default:                  start_char    <= start_char;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      dilf_pkg::REG_START_CHAR: prdata = {24'd0, start_char};
      dilf_pkg::REG_END_CHAR:   prdata = {24'd0, end_char};
      dilf_pkg::REG_DEVICE_ID:  prdata = device_id;
      dilf_pkg::REG_DEAD_MS:    prdata = {16'd0, dead_after_ms};
      default:                  prdata = 32'd0;
    endcase
  end

  dilf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (in_data.opcode),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  dilf_dp #(
    .LINE_CHARS (LINE_CHARS),
    .ID_CHARS   (ID_CHARS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .rx_byte       (in_data.rx_byte),
    .start_char    (start_char),
    .end_char      (end_char),
    .device_id     (device_id),
    .dead_after_ms (dead_after_ms),
    .out_ready     (out_ready),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_data      (out_data)
  );

  a_ready_needs_room: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!out_valid || out_ready))
    else $error("input taken while output register is blocked");

  a_start_silent: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.opcode == dilf_pkg::OP_START) |=> !out_valid)
    else $error("session start produced a result");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.event_res == dilf_pkg::EV_DEAD ||
                   out_data.event_res == dilf_pkg::EV_FAIL)) |-> out_data.last)
    else $error("session end word not marked last");

  a_event_data_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.event_res != dilf_pkg::EV_CHAR) |-> (out_data.data_byte == 8'd0))
    else $error("event word carries data");

endmodule
